// File: rtl/ctm_pkg.sv
// Shared types, token and error codes and character helpers of the C-minus token scanner.
package ctm_pkg;

  // Token kind codes
  localparam logic [4:0] KIND_EOF    = 5'd0;
  localparam logic [4:0] KIND_ERROR  = 5'd1;
  localparam logic [4:0] KIND_ID     = 5'd2;
  localparam logic [4:0] KIND_NUM    = 5'd3;
  localparam logic [4:0] KIND_ELSE   = 5'd4;
  localparam logic [4:0] KIND_IF     = 5'd5;
  localparam logic [4:0] KIND_INT    = 5'd6;
  localparam logic [4:0] KIND_RETURN = 5'd7;
  localparam logic [4:0] KIND_VOID   = 5'd8;
  localparam logic [4:0] KIND_WHILE  = 5'd9;
  localparam logic [4:0] KIND_PLUS   = 5'd10;
  localparam logic [4:0] KIND_MINUS  = 5'd11;
  localparam logic [4:0] KIND_STAR   = 5'd12;
  localparam logic [4:0] KIND_SLASH  = 5'd13;
  localparam logic [4:0] KIND_ASSIGN = 5'd14;
  localparam logic [4:0] KIND_EQ     = 5'd15;
  localparam logic [4:0] KIND_NE     = 5'd16;
  localparam logic [4:0] KIND_LT     = 5'd17;
  localparam logic [4:0] KIND_LE     = 5'd18;
  localparam logic [4:0] KIND_GT     = 5'd19;
  localparam logic [4:0] KIND_GE     = 5'd20;
  localparam logic [4:0] KIND_LPAREN = 5'd21;
  localparam logic [4:0] KIND_RPAREN = 5'd22;
  localparam logic [4:0] KIND_LBRACE = 5'd23;
  localparam logic [4:0] KIND_RBRACE = 5'd24;
  localparam logic [4:0] KIND_LBRACK = 5'd25;
  localparam logic [4:0] KIND_RBRACK = 5'd26;
  localparam logic [4:0] KIND_COMMA  = 5'd27;
  localparam logic [4:0] KIND_SEMI   = 5'd28;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_COMMENT = 2'd1;
  localparam logic [1:0] ERR_BANG    = 2'd2;
  localparam logic [1:0] ERR_UNKNOWN = 2'd3;

  // Characters with a role of their own
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_GT      = 8'h3E;

  // Keyword texts, right aligned in the 48-bit prefix
  localparam logic [47:0] KW_ELSE   = 48'h0000_656C_7365;
  localparam logic [47:0] KW_IF     = 48'h0000_0000_6966;
  localparam logic [47:0] KW_INT    = 48'h0000_0069_6E74;
  localparam logic [47:0] KW_RETURN = 48'h7265_7475_726E;
  localparam logic [47:0] KW_VOID   = 48'h0000_766F_6964;
  localparam logic [47:0] KW_WHILE  = 48'h0077_6869_6C65;

  localparam logic [23:0] LINE_MAX = 24'hFF_FFFF;

  // Depth of the result queue
  localparam int FIFO_DEPTH = 4;

  // One result word
  typedef struct packed {
    logic [4:0]  kind;
    logic [1:0]  err;
    logic [7:0]  bad_byte;
    logic [31:0] start;
    logic [7:0]  len;
    logic        ovf;
    logic [23:0] line;
    logic        last;
  } token_t;

  // Results of one scanned item
  typedef struct packed {
    logic [1:0] count;
    token_t     word0;
    token_t     word1;
  } push_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  // One-character tokens that never pair; KIND_EOF means none
  function automatic logic [4:0] single_kind(input logic [7:0] b);
    case (b)
      8'h2B:   return KIND_PLUS;   // +
      8'h2D:   return KIND_MINUS;  // -
      8'h2A:   return KIND_STAR;   // *
      8'h28:   return KIND_LPAREN;
      8'h29:   return KIND_RPAREN;
      8'h7B:   return KIND_LBRACE;
      8'h7D:   return KIND_RBRACE;
      8'h5B:   return KIND_LBRACK;
      8'h5D:   return KIND_RBRACK;
      8'h2C:   return KIND_COMMA;
      8'h3B:   return KIND_SEMI;
      default: return KIND_EOF;
    endcase
  endfunction

  function automatic token_t make_token(input logic [4:0] kind, input logic [1:0] err,
                                        input logic [7:0] bad_byte, input logic [31:0] start,
                                        input logic [7:0] len, input logic ovf,
                                        input logic [23:0] line);
    token_t t;
    t.kind     = kind;
    t.err      = err;
    t.bad_byte = bad_byte;
    t.start    = start;
    t.len      = len;
    t.ovf      = ovf;
    t.line     = line;
    t.last     = 1'b0;
    return t;
  endfunction

endpackage

// File: rtl/c_minus_token_scanner_top.sv
// Top level of the C-minus token scanner: byte input channel and token output channel.
// Takes one source byte (or an end-of-text mark) per cycle and gives tokens with kind,
// error code, start offset, length, line and a flag on the last token of each word.
// A byte is taken in the cycle it arrives as long as the four-word token queue has two
// free places, so a steady stream runs at one byte per clock; a byte that finishes one
// token and yields another (for example "x+") puts two words in the queue, and the output
// side then gives them one at a time. The scan itself is one pass of logic per byte on
// the stored scanner state; tokens are written to the queue at the clock edge that takes
// the byte that completes them. Identifier and number lengths stop at MAX_LEXEME.
module c_minus_token_scanner_top #(
  parameter int MAX_LEXEME = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_byte,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  token_kind,
  output logic [1:0]  error_kind,
  output logic [7:0]  offending_byte,
  output logic [31:0] start_offset,
  output logic [7:0]  lexeme_length,
  output logic        length_overflow,
  output logic [23:0] line_number,
  output logic        last_of_run
);

  ctm_pkg::push_t  push;
  ctm_pkg::token_t head;
  logic            fire;

  assign fire = in_valid && in_ready;

  // Per-byte scan
  ctm_scan_core #(
    .MAX_LEXEME (MAX_LEXEME)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .char_byte    (char_byte),
    .end_of_input (end_of_input),
    .push         (push)
  );

  // Token queue
  ctm_token_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // Output fields
  assign token_kind      = head.kind;
  assign error_kind      = head.err;
  assign offending_byte  = head.bad_byte;
  assign start_offset    = head.start;
  assign lexeme_length   = head.len;
  assign length_overflow = head.ovf;
  assign line_number     = head.line;
  assign last_of_run     = head.last;

endmodule

// File: rtl/ctm_scan_core.sv
// Scanner state and the single-pass next-state and token logic for one byte.
module ctm_scan_core #(
  parameter int MAX_LEXEME = 255
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  logic [7:0]    char_byte,
  input  logic          end_of_input,
  output ctm_pkg::push_t push
);

  localparam int LEN_W = $clog2(MAX_LEXEME + 1);

  localparam logic [3:0] PH_START   = 4'd0;
  localparam logic [3:0] PH_WORD    = 4'd1;
  localparam logic [3:0] PH_NUMBER  = 4'd2;
  localparam logic [3:0] PH_SLASH   = 4'd3;
  localparam logic [3:0] PH_COMMENT = 4'd4;
  localparam logic [3:0] PH_CSTAR   = 4'd5;
  localparam logic [3:0] PH_EQ      = 4'd6;
  localparam logic [3:0] PH_BANG    = 4'd7;
  localparam logic [3:0] PH_LT      = 4'd8;
  localparam logic [3:0] PH_GT      = 4'd9;

  logic [3:0]       phase, phase_next;
  logic [47:0]      prefix, prefix_next;
  logic [LEN_W-1:0] plen, plen_next;
  logic             povf, povf_next;
  logic [31:0]      pstart, pstart_next;
  logic [23:0]      pline, pline_next;
  logic [23:0]      line_count, line_count_next;
  logic [31:0]      byte_offset, byte_offset_next;

  logic [7:0]       b;
  logic             eoi, more, redo;
  logic             a_v, b_v;
  ctm_pkg::token_t  tok_a, tok_b;
  logic [47:0]      ext_prefix;
  logic [LEN_W-1:0] ext_len;
  logic             ext_ovf;
  logic [23:0]      line_inc;
  logic [4:0]       word_kind, two_kind, one_kind;
  logic [4:0]       sk;

  assign b    = char_byte;
  assign eoi  = end_of_input;
  assign more = !end_of_input;

  // Growing a pending id or number by one byte
  assign ext_prefix = (plen < LEN_W'(6)) ? {prefix[39:0], b} : prefix;
  assign ext_len    = (plen < LEN_W'(MAX_LEXEME)) ? plen + LEN_W'(1) : plen;
  assign ext_ovf    = povf | !(plen < LEN_W'(MAX_LEXEME));
  assign line_inc   = (line_count == ctm_pkg::LINE_MAX) ? line_count
                                                        : line_count + 24'd1;
  assign sk         = ctm_pkg::single_kind(b);

  // Keyword match on a finished word
  always_comb begin
    word_kind = ctm_pkg::KIND_ID;
    if (!povf) begin
      if (plen == LEN_W'(4) && prefix == ctm_pkg::KW_ELSE)   word_kind = ctm_pkg::KIND_ELSE;
      if (plen == LEN_W'(2) && prefix == ctm_pkg::KW_IF)     word_kind = ctm_pkg::KIND_IF;
      if (plen == LEN_W'(3) && prefix == ctm_pkg::KW_INT)    word_kind = ctm_pkg::KIND_INT;
      if (plen == LEN_W'(6) && prefix == ctm_pkg::KW_RETURN) word_kind = ctm_pkg::KIND_RETURN;
      if (plen == LEN_W'(4) && prefix == ctm_pkg::KW_VOID)   word_kind = ctm_pkg::KIND_VOID;
      if (plen == LEN_W'(5) && prefix == ctm_pkg::KW_WHILE)  word_kind = ctm_pkg::KIND_WHILE;
    end
  end

  // Two- and one-character kinds of a pending operator
  always_comb begin
    case (phase)
      PH_EQ:   begin two_kind = ctm_pkg::KIND_EQ; one_kind = ctm_pkg::KIND_ASSIGN; end
      PH_LT:   begin two_kind = ctm_pkg::KIND_LE; one_kind = ctm_pkg::KIND_LT; end
      PH_GT:   begin two_kind = ctm_pkg::KIND_GE; one_kind = ctm_pkg::KIND_GT; end
      default: begin two_kind = ctm_pkg::KIND_NE; one_kind = ctm_pkg::KIND_ERROR; end
    endcase
  end

  // Continue or finish the pending token; a byte that does not belong to it is scanned from between tokens
  always_comb begin
    phase_next       = phase;
    prefix_next      = prefix;
    plen_next        = plen;
    povf_next        = povf;
    pstart_next      = pstart;
    pline_next       = pline;
    line_count_next  = line_count;
    byte_offset_next = byte_offset;
    a_v   = 1'b0;
    b_v   = 1'b0;
    redo  = 1'b0;
    tok_a = '0;
    tok_b = '0;

    case (phase)
      PH_WORD: begin
        if (more && ctm_pkg::is_letter(b)) begin
          prefix_next = ext_prefix;
          plen_next   = ext_len;
          povf_next   = ext_ovf;
        end else begin
          a_v   = 1'b1;
          tok_a = ctm_pkg::make_token(word_kind, ctm_pkg::ERR_NONE, 8'd0, pstart,
                                      8'(plen), povf, pline);
          redo  = 1'b1;
        end
      end
      PH_NUMBER: begin
        if (more && ctm_pkg::is_digit(b)) begin
          prefix_next = ext_prefix;
          plen_next   = ext_len;
          povf_next   = ext_ovf;
        end else begin
          a_v   = 1'b1;
          tok_a = ctm_pkg::make_token(ctm_pkg::KIND_NUM, ctm_pkg::ERR_NONE, 8'd0, pstart,
                                      8'(plen), povf, pline);
          redo  = 1'b1;
        end
      end
      PH_SLASH: begin
        if (more && b == ctm_pkg::CH_STAR) begin
          phase_next = PH_COMMENT;
        end else begin
          a_v   = 1'b1;
          tok_a = ctm_pkg::make_token(ctm_pkg::KIND_SLASH, ctm_pkg::ERR_NONE, 8'd0, pstart,
                                      8'd1, 1'b0, pline);
          redo  = 1'b1;
        end
      end
      PH_COMMENT, PH_CSTAR: begin
        if (eoi) begin
          a_v   = 1'b1;
          tok_a = ctm_pkg::make_token(ctm_pkg::KIND_ERROR, ctm_pkg::ERR_COMMENT, 8'd0,
                                      pstart, 8'd2, 1'b0, pline);
          redo  = 1'b1;
        end else if (b == ctm_pkg::CH_STAR) begin
          phase_next = PH_CSTAR;
        end else if (b == ctm_pkg::CH_SLASH && phase == PH_CSTAR) begin
          phase_next = PH_START;
        end else begin
          if (b == ctm_pkg::CH_NEWLINE) line_count_next = line_inc;
          phase_next = PH_COMMENT;
        end
      end
      PH_EQ, PH_LT, PH_GT, PH_BANG: begin
        a_v = 1'b1;
        if (more && b == ctm_pkg::CH_EQUAL) begin
          tok_a      = ctm_pkg::make_token(two_kind, ctm_pkg::ERR_NONE, 8'd0, pstart,
                                           8'd2, 1'b0, pline);
          phase_next = PH_START;
        end else begin
          tok_a = ctm_pkg::make_token(one_kind,
                                      (phase == PH_BANG) ? ctm_pkg::ERR_BANG
                                                         : ctm_pkg::ERR_NONE,
                                      8'd0, pstart, 8'd1, 1'b0, pline);
          redo  = 1'b1;
        end
      end
      default: begin
        redo = 1'b1;
      end
    endcase

    // Scan from between tokens
    if (redo) begin
      phase_next = PH_START;
      if (eoi) begin
        b_v   = 1'b1;
        tok_b = ctm_pkg::make_token(ctm_pkg::KIND_EOF, ctm_pkg::ERR_NONE, 8'd0, byte_offset,
                                    8'd0, 1'b0, line_count);
      end else if (ctm_pkg::is_space(b)) begin
        if (b == ctm_pkg::CH_NEWLINE) line_count_next = line_inc;
      end else if (ctm_pkg::is_letter(b) || ctm_pkg::is_digit(b) ||
                   b == ctm_pkg::CH_SLASH || b == ctm_pkg::CH_EQUAL ||
                   b == ctm_pkg::CH_BANG || b == ctm_pkg::CH_LT || b == ctm_pkg::CH_GT) begin
        if (ctm_pkg::is_letter(b))       phase_next = PH_WORD;
        else if (ctm_pkg::is_digit(b))   phase_next = PH_NUMBER;
        else if (b == ctm_pkg::CH_SLASH) phase_next = PH_SLASH;
        else if (b == ctm_pkg::CH_EQUAL) phase_next = PH_EQ;
        else if (b == ctm_pkg::CH_BANG)  phase_next = PH_BANG;
        else if (b == ctm_pkg::CH_LT)    phase_next = PH_LT;
        else                             phase_next = PH_GT;
        pstart_next = byte_offset;
        pline_next  = line_count;
        plen_next   = LEN_W'(1);
        povf_next   = 1'b0;
        prefix_next = {40'd0, b};
      end else if (sk != ctm_pkg::KIND_EOF) begin
        b_v   = 1'b1;
        tok_b = ctm_pkg::make_token(sk, ctm_pkg::ERR_NONE, 8'd0, byte_offset, 8'd1, 1'b0,
                                    line_count);
      end else begin
        b_v   = 1'b1;
        tok_b = ctm_pkg::make_token(ctm_pkg::KIND_ERROR, ctm_pkg::ERR_UNKNOWN, b,
                                    byte_offset, 8'd1, 1'b0, line_count);
      end
    end

    // End of text restarts the counters
    if (eoi) begin
      phase_next       = PH_START;
      byte_offset_next = 32'd0;
      line_count_next  = 24'd1;
    end else begin
      byte_offset_next = byte_offset + 32'd1;
    end
  end

  // Result words of this byte, the last one flagged
  always_comb begin
    push.count = fire ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
    push.word0 = a_v ? tok_a : tok_b;
    push.word1 = tok_b;
    push.word0.last = !(a_v && b_v);
    push.word1.last = 1'b1;
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      prefix      <= 48'd0;
      plen        <= '0;
      povf        <= 1'b0;
      pstart      <= 32'd0;
      pline       <= 24'd1;
      line_count  <= 24'd1;
      byte_offset <= 32'd0;
    end else if (fire) begin
      phase       <= phase_next;
      prefix      <= prefix_next;
      plen        <= plen_next;
      povf        <= povf_next;
      pstart      <= pstart_next;
      pline       <= pline_next;
      line_count  <= line_count_next;
      byte_offset <= byte_offset_next;
    end
  end

  // End of text always yields at least the EOF word and resets the position
  a_eoi_emits: assert property (@(posedge clk) disable iff (rst)
    (fire && end_of_input) |-> (push.count != 2'd0))
    else $error("end of text produced no token");

  a_eoi_restart: assert property (@(posedge clk) disable iff (rst)
    (fire && end_of_input) |=> (byte_offset == 32'd0 && line_count == 24'd1))
    else $error("position not restarted after end of text");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    plen <= LEN_W'(MAX_LEXEME))
    else $error("pending length beyond maximum");

endmodule

// File: rtl/ctm_token_fifo.sv
// Four-word result queue taking up to two tokens per cycle and giving one while out_ready is high.
module ctm_token_fifo (
  input  logic            clk,
  input  logic            rst,
  input  ctm_pkg::push_t  push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output ctm_pkg::token_t head
);

  localparam int PTR_W = $clog2(ctm_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(ctm_pkg::FIFO_DEPTH + 1);

  ctm_pkg::token_t  mem [ctm_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;

  assign room      = count <= CNT_W'(ctm_pkg::FIFO_DEPTH - 2);
  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign head      = mem[rd_ptr];
  assign count_next = count + CNT_W'(push.count) - CNT_W'(pop);

  // Storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.word0;
    if (push.count == 2'd2) mem[wr_ptr + PTR_W'(1)] <= push.word1;
  end

  // Pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count  <= count_next;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ctm_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (count <= CNT_W'(ctm_pkg::FIFO_DEPTH - 2)))
    else $error("tokens pushed without room for two");

  a_pop_advance: assert property (@(posedge clk) disable iff (rst)
    pop |=> (rd_ptr == $past(rd_ptr) + PTR_W'(1)))
    else $error("read pointer did not advance on pop");

endmodule

// File: verif/tb_c_minus_token_scanner_top.sv
`timescale 1ns / 100ps
// Testbench of the C-minus token scanner: scripted and random source text, token-by-token check.
module tb_c_minus_token_scanner_top;

  localparam int MAX_LEN         = 255;
  localparam int TEXT_ITEMS      = 1200;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 20;
  localparam int RUN_LIMIT_NS    = 15_000_000;
  localparam int MAX_REPORTS     = 10;

  // Scanner shadow: tracks lexer state per byte word and queues the tokens it must give
  class token_scoreboard;
    typedef enum logic [3:0] {
      SC_IDLE, SC_WORD, SC_NUMBER, SC_SLASH, SC_COMMENT, SC_CSTAR,
      SC_EQ, SC_BANG, SC_LT, SC_GT
    } scan_phase_t;

    scan_phase_t     phase;
    logic [47:0]     kw_prefix;
    logic [7:0]      pend_len;
    bit              pend_ovf;
    logic [31:0]     pend_start;
    logic [23:0]     pend_line;
    logic [23:0]     line_cnt;
    logic [31:0]     offset;
    ctm_pkg::token_t due_tokens[$];
    ctm_pkg::token_t step_tokens[$];
    int              mismatches;

    function new();
      phase      = SC_IDLE;
      kw_prefix  = '0;
      pend_len   = '0;
      pend_ovf   = 1'b0;
      pend_start = '0;
      pend_line  = 24'd1;
      line_cnt   = 24'd1;
      offset     = '0;
      mismatches = 0;
    endfunction

    function bit alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function bit numeral(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit blank(logic [7:0] b);
      return b == " " || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function void add_token(logic [4:0] kind, logic [1:0] err, logic [7:0] bad,
                            logic [31:0] start, logic [7:0] len, bit ovf,
                            logic [23:0] line);
      ctm_pkg::token_t t;
      t.kind     = kind;
      t.err      = err;
      t.bad_byte = bad;
      t.start    = start;
      t.len      = len;
      t.ovf      = ovf;
      t.line     = line;
      t.last     = 1'b0;
      step_tokens.push_back(t);
    endfunction

    function void bump_line();
      if (line_cnt != ctm_pkg::LINE_MAX) line_cnt++;
    endfunction

    function void open_lexeme(scan_phase_t ph, logic [7:0] b);
      phase      = ph;
      pend_start = offset;
      pend_line  = line_cnt;
      pend_len   = 8'd1;
      pend_ovf   = 1'b0;
      kw_prefix  = {40'd0, b};
    endfunction

    // prefix only holds the first six bytes; length sticks at the maximum
    function void grow_lexeme(logic [7:0] b);
      if (pend_len < 6) kw_prefix = {kw_prefix[39:0], b};
      if (pend_len < MAX_LEN) pend_len++;
      else pend_ovf = 1'b1;
    endfunction

    function logic [4:0] word_kind();
      if (pend_ovf) return ctm_pkg::KIND_ID;
      case (pend_len)
        8'd2: if (kw_prefix == ctm_pkg::KW_IF) return ctm_pkg::KIND_IF;
        8'd3: if (kw_prefix == ctm_pkg::KW_INT) return ctm_pkg::KIND_INT;
        8'd4: begin
          if (kw_prefix == ctm_pkg::KW_ELSE) return ctm_pkg::KIND_ELSE;
          if (kw_prefix == ctm_pkg::KW_VOID) return ctm_pkg::KIND_VOID;
        end
        8'd5: if (kw_prefix == ctm_pkg::KW_WHILE) return ctm_pkg::KIND_WHILE;
        8'd6: if (kw_prefix == ctm_pkg::KW_RETURN) return ctm_pkg::KIND_RETURN;
        default: ;
      endcase
      return ctm_pkg::KIND_ID;
    endfunction

    // single-byte tokens that never pair up; EOF code means none
    function logic [4:0] lone_kind(logic [7:0] b);
      case (b)
        "+":     return ctm_pkg::KIND_PLUS;
        "-":     return ctm_pkg::KIND_MINUS;
        "*":     return ctm_pkg::KIND_STAR;
        "(":     return ctm_pkg::KIND_LPAREN;
        ")":     return ctm_pkg::KIND_RPAREN;
        "{":     return ctm_pkg::KIND_LBRACE;
        "}":     return ctm_pkg::KIND_RBRACE;
        "[":     return ctm_pkg::KIND_LBRACK;
        "]":     return ctm_pkg::KIND_RBRACK;
        ",":     return ctm_pkg::KIND_COMMA;
        ";":     return ctm_pkg::KIND_SEMI;
        default: return ctm_pkg::KIND_EOF;
      endcase
    endfunction

    // scan a byte (or the end mark) from the between-tokens state
    function void restart(bit eoi, logic [7:0] b);
      logic [4:0] k;
      phase = SC_IDLE;
      if (eoi) begin
        add_token(ctm_pkg::KIND_EOF, ctm_pkg::ERR_NONE, 8'd0, offset, 8'd0, 1'b0, line_cnt);
        return;
      end
      if (blank(b)) begin
        if (b == ctm_pkg::CH_NEWLINE) bump_line();
        return;
      end
      if (alpha(b)) begin
        open_lexeme(SC_WORD, b);
        return;
      end
      if (numeral(b)) begin
        open_lexeme(SC_NUMBER, b);
        return;
      end
      case (b)
        ctm_pkg::CH_SLASH: begin open_lexeme(SC_SLASH, b); return; end
        ctm_pkg::CH_EQUAL: begin open_lexeme(SC_EQ, b); return; end
        ctm_pkg::CH_BANG:  begin open_lexeme(SC_BANG, b); return; end
        ctm_pkg::CH_LT:    begin open_lexeme(SC_LT, b); return; end
        ctm_pkg::CH_GT:    begin open_lexeme(SC_GT, b); return; end
        default:  ;
      endcase
      k = lone_kind(b);
      if (k != ctm_pkg::KIND_EOF)
        add_token(k, ctm_pkg::ERR_NONE, 8'd0, offset, 8'd1, 1'b0, line_cnt);
      else
        add_token(ctm_pkg::KIND_ERROR, ctm_pkg::ERR_UNKNOWN, b, offset, 8'd1, 1'b0, line_cnt);
    endfunction

    // accepted input word: advance the shadow state and queue its tokens
    function void note_byte(logic [7:0] b, bit eoi);
      bit              redo;
      logic [4:0]      pair_k;
      logic [4:0]      one_k;
      ctm_pkg::token_t t;
      redo = 1'b0;
      step_tokens.delete();
      case (phase)
        SC_WORD:
          if (!eoi && alpha(b)) grow_lexeme(b);
          else begin
            add_token(word_kind(), ctm_pkg::ERR_NONE, 8'd0, pend_start, pend_len, pend_ovf,
                      pend_line);
            redo = 1'b1;
          end
        SC_NUMBER:
          if (!eoi && numeral(b)) grow_lexeme(b);
          else begin
            add_token(ctm_pkg::KIND_NUM, ctm_pkg::ERR_NONE, 8'd0, pend_start, pend_len,
                      pend_ovf, pend_line);
            redo = 1'b1;
          end
        SC_SLASH:
          if (!eoi && b == ctm_pkg::CH_STAR) phase = SC_COMMENT;
          else begin
            add_token(ctm_pkg::KIND_SLASH, ctm_pkg::ERR_NONE, 8'd0, pend_start, 8'd1, 1'b0,
                      pend_line);
            redo = 1'b1;
          end
        SC_COMMENT, SC_CSTAR:
          if (eoi) begin
            add_token(ctm_pkg::KIND_ERROR, ctm_pkg::ERR_COMMENT, 8'd0, pend_start, 8'd2, 1'b0,
                      pend_line);
            redo = 1'b1;
          end else if (b == ctm_pkg::CH_STAR) begin
            phase = SC_CSTAR;
          end else if (b == ctm_pkg::CH_SLASH && phase == SC_CSTAR) begin
            phase = SC_IDLE;
          end else begin
            if (b == ctm_pkg::CH_NEWLINE) bump_line();
            phase = SC_COMMENT;
          end
        SC_EQ, SC_LT, SC_GT, SC_BANG: begin
          case (phase)
            SC_EQ:   begin pair_k = ctm_pkg::KIND_EQ; one_k = ctm_pkg::KIND_ASSIGN; end
            SC_LT:   begin pair_k = ctm_pkg::KIND_LE; one_k = ctm_pkg::KIND_LT; end
            SC_GT:   begin pair_k = ctm_pkg::KIND_GE; one_k = ctm_pkg::KIND_GT; end
            default: begin pair_k = ctm_pkg::KIND_NE; one_k = ctm_pkg::KIND_ERROR; end
          endcase
          if (!eoi && b == ctm_pkg::CH_EQUAL) begin
            add_token(pair_k, ctm_pkg::ERR_NONE, 8'd0, pend_start, 8'd2, 1'b0, pend_line);
            phase = SC_IDLE;
          end else begin
            if (phase == SC_BANG)
              add_token(ctm_pkg::KIND_ERROR, ctm_pkg::ERR_BANG, 8'd0, pend_start, 8'd1, 1'b0,
                        pend_line);
            else
              add_token(one_k, ctm_pkg::ERR_NONE, 8'd0, pend_start, 8'd1, 1'b0, pend_line);
            redo = 1'b1;
          end
        end
        default: redo = 1'b1;
      endcase

      if (redo) restart(eoi, b);

      // end mark starts a fresh text
      if (eoi) begin
        phase    = SC_IDLE;
        offset   = '0;
        line_cnt = 24'd1;
      end else begin
        offset++;
      end

      if (step_tokens.size() > 0) begin
        t = step_tokens.pop_back();
        t.last = 1'b1;
        step_tokens.push_back(t);
      end
      foreach (step_tokens[i]) due_tokens.push_back(step_tokens[i]);
    endfunction

    // accepted output word against the oldest queued token
    function void check_token(ctm_pkg::token_t got);
      ctm_pkg::token_t want;
      if (due_tokens.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: token with nothing queued: kind %0d start %0d len %0d",
                   $realtime, got.kind, got.start, got.len);
        mismatches++;
        return;
      end
      want = due_tokens.pop_front();
      if (got.kind !== want.kind || got.err !== want.err ||
          got.bad_byte !== want.bad_byte || got.start !== want.start ||
          got.len !== want.len || got.ovf !== want.ovf ||
          got.line !== want.line || got.last !== want.last) begin
        if (mismatches < MAX_REPORTS) begin
          $display("%0t: token mismatch", $realtime);
          $display("  exp kind %0d err %0d byte %h start %0d len %0d ovf %0d line %0d last %0d",
                   want.kind, want.err, want.bad_byte, want.start, want.len, want.ovf,
                   want.line, want.last);
          $display("  got kind %0d err %0d byte %h start %0d len %0d ovf %0d line %0d last %0d",
                   got.kind, got.err, got.bad_byte, got.start, got.len, got.ovf,
                   got.line, got.last);
        end
        mismatches++;
      end
    endfunction

    function int waiting();
      return due_tokens.size();
    endfunction
  endclass

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  char_byte    = 8'd0;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [4:0]  token_kind;
  logic [1:0]  error_kind;
  logic [7:0]  offending_byte;
  logic [31:0] start_offset;
  logic [7:0]  lexeme_length;
  logic        length_overflow;
  logic [23:0] line_number;
  logic        last_of_run;

  token_scoreboard sb;
  int  sent         = 0;
  int  long_items   = 0;
  bit  calm         = 1'b0;
  bit  hold_off_req = 1'b0;

  c_minus_token_scanner_top #(
    .MAX_LEXEME(MAX_LEN)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_byte      (char_byte),
    .end_of_input   (end_of_input),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .token_kind     (token_kind),
    .error_kind     (error_kind),
    .offending_byte (offending_byte),
    .start_offset   (start_offset),
    .lexeme_length  (lexeme_length),
    .length_overflow(length_overflow),
    .line_number    (line_number),
    .last_of_run    (last_of_run)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] x;
    x = 8'($urandom_range(25));
    return $urandom_range(1) ? 8'h61 + x : 8'h41 + x;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  // Offer one word and hold it until the scanner takes it
  task automatic send_item(logic [7:0] b, bit eoi);
    int gap;
    if ($urandom_range(63) == 0) calm = !calm;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    char_byte    <= b;
    end_of_input <= eoi;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  // Identifier or number longer than or at the length limit
  task automatic send_long(bit digits, int len);
    int before_cnt;
    before_cnt = sent;
    send_item(" ", 1'b0);
    if (!digits) send_text("while");
    for (int i = digits ? 0 : 5; i < len; i++)
      send_item(digits ? rand_digit() : rand_letter(), 1'b0);
    send_item(" ", 1'b0);
    long_items += sent - before_cnt;
  endtask

  // One random piece of source: mostly well-formed tokens, some noise
  task automatic send_fragment();
    string kw_words[6];
    string op_words[19];
    int    r;
    int    n;
    int    pick;
    logic [7:0] blanks[6];
    kw_words = '{"else", "if", "int", "return", "void", "while"};
    op_words = '{"+", "-", "*", "/", "=", "==", "!=", "<", "<=", ">", ">=",
                 "(", ")", "{", "}", "[", "]", ",", ";"};
    blanks   = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    r = $urandom_range(99);
    if (r < 12) begin
      send_text(kw_words[$urandom_range(5)]);
    end else if (r < 30) begin
      // keyword with a tail, or a plain identifier
      if ($urandom_range(3) == 0) begin
        send_text(kw_words[$urandom_range(5)]);
        send_item(rand_letter(), 1'b0);
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) send_item(rand_letter(), 1'b0);
      end
    end else if (r < 42) begin
      n = $urandom_range(1, 7);
      repeat (n) send_item(rand_digit(), 1'b0);
    end else if (r < 65) begin
      send_text(op_words[$urandom_range(18)]);
    end else if (r < 75) begin
      send_text("/*");
      n = $urandom_range(0, 10);
      repeat (n) begin
        pick = $urandom_range(9);
        case (pick)
          0, 1, 2, 3: send_item(rand_letter(), 1'b0);
          4:          send_item(ctm_pkg::CH_STAR, 1'b0);
          5:          send_item(ctm_pkg::CH_NEWLINE, 1'b0);
          6:          send_item(ctm_pkg::CH_SLASH, 1'b0);
          7:          send_item(" ", 1'b0);
          default:    send_item(8'($urandom_range(255)), 1'b0);
        endcase
      end
      send_text("*/");
    end else if (r < 80) begin
      n = $urandom_range(1, 4);
      repeat (n) send_item(blanks[$urandom_range(5)], 1'b0);
    end else if (r < 92) begin
      send_item(8'($urandom_range(255)), 1'b0);
    end else if (r < 95) begin
      send_item(ctm_pkg::CH_BANG, 1'b0);
    end else if (r < 97) begin
      // comment left open at the end of the text
      send_text("/*");
      n = $urandom_range(0, 3);
      repeat (n) send_item(($urandom_range(1)) ? ctm_pkg::CH_NEWLINE : rand_letter(), 1'b0);
      send_end();
    end else begin
      send_end();
    end
    if ($urandom_range(1)) send_item(blanks[$urandom_range(5)], 1'b0);
  endtask

  // Input and output word monitor
  always @(posedge clk) begin : watch
    ctm_pkg::token_t got;
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(char_byte, end_of_input);
      if (out_valid && out_ready) begin
        got = '{kind: token_kind, err: error_kind, bad_byte: offending_byte,
                start: start_offset, len: lexeme_length, ovf: length_overflow,
                line: line_number, last: last_of_run};
        sb.check_token(got);
      end
    end
  end

  // Token receiver: random stalls plus one long hold-off on request
  initial begin : receiver
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 80 : 6)) @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        n = HOLD_OFF_CYCLES;
      end else begin
        n = pick_gap();
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("[c_minus_token_scanner_top] ERROR");
    $finish;
  end

  // Stimulus and end of run
  initial begin : stimulus
    int base;
    int long_done;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unknown bytes at both ends of the range
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h7F, 1'b0);
    // lone bang before a letter, then a proper not-equal
    send_text("!x!=");
    // end mark twice in a row
    send_end();
    send_end();
    // open comment spanning a newline, cut by the end mark
    send_text("/*\n*");
    send_end();
    // keyword, pending operators and a flush of two tokens on the end mark
    send_text("\tif<9>==");
    send_end();

    // random text with one long receiver hold-off near the start
    hold_off_req = 1'b1;
    base      = sent;
    long_done = 0;
    while (sent - base < TEXT_ITEMS) begin
      if (long_done < 3 && sent - long_items - base >= 100 * (long_done + 1)) begin
        case (long_done)
          0:       send_long(1'b0, MAX_LEN);
          1:       send_long(1'b0, $urandom_range(MAX_LEN + 1, MAX_LEN + 12));
          default: send_long(1'b1, $urandom_range(MAX_LEN + 1, MAX_LEN + 12));
        endcase
        long_done++;
      end
      send_fragment();
    end
    send_end();
    in_valid <= 1'b0;

    // drain
    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.waiting() == 0)
      $display("[c_minus_token_scanner_top] OK");
    else
      $display("[c_minus_token_scanner_top] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/ctm_pkg.sv
rtl/ctm_scan_core.sv
rtl/ctm_token_fifo.sv
rtl/c_minus_token_scanner_top.sv
verif/tb_c_minus_token_scanner_top.sv
